// ===== design/pms_pkg.sv =====
// Shared types, codes and constants of the partitioned multi-stack unit.
package pms_pkg;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 5;

    // Build defaults and register reset value
    localparam int NUM_STACKS_DEF = 2;
    localparam int MAX_DEPTH_DEF  = 16;
    localparam int DEPTH_RESET    = 16;

    // Operation codes of an input item
    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 2'd0,
        OP_POP      = 2'd1,
        OP_LIST     = 2'd2,
        OP_LIST_ALL = 2'd3
    } t_op;

    // Status codes of a result item
    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED    = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_POPPED    = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_LISTED    = 3'd4,
        ST_END       = 3'd5
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_item;    // capture the accepted item
        logic    push_wr;      // write value on top of current stack, bump fill
        logic    pop_rd;       // read top of current stack, drop fill
        logic    list_init;    // start a listing walk
        logic    list_rd;      // read the entry at the walk index
        logic    idx_inc;      // advance the walk index
        logic    next_stack;   // move the walk to the next stack
        logic    emit;         // load the output register
        t_status emit_status;
        logic    emit_rdata;   // value from memory, else zero
        logic    emit_zero_id; // stack id forced to zero
        logic    emit_last;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_op  op;
        logic full;       // current stack partition is full
        logic empty;      // current stack holds nothing
        logic list_more;  // walk index below current fill
        logic has_next;   // another stack follows the current one
        logic out_free;   // output register can take an item
    } t_sts;

endpackage

// ===== design/pms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pms_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pms_dpath.sv =====
// Datapath: depth register, fill counts, walk cursor, element memory, output register.
module pms_dpath #(
    parameter int NUM_STACKS = pms_pkg::NUM_STACKS_DEF,
    parameter int MAX_DEPTH  = pms_pkg::MAX_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [pms_pkg::CFG_W-1:0]    i_cfg_wdata,
    // captured item fields
    input  pms_pkg::t_op                 i_op,
    input  logic                         i_sel,
    input  logic [pms_pkg::VALUE_W-1:0]  i_value,
    // control
    input  pms_pkg::t_cmd                i_cmd,
    output pms_pkg::t_sts                o_sts,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pms_pkg::STATUS_W-1:0] o_out_status,
    output logic                         o_out_id,
    output logic [pms_pkg::VALUE_W-1:0]  o_out_value,
    output logic                         o_out_last
);

    localparam int STK_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int MEM_D   = NUM_STACKS * MAX_DEPTH;
    localparam int ADDR_W  = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam int RST_D   = (pms_pkg::DEPTH_RESET > MAX_DEPTH) ? MAX_DEPTH
                                                                : pms_pkg::DEPTH_RESET;

    pms_pkg::t_op                 r_op;
    logic [pms_pkg::VALUE_W-1:0]  r_value;
    logic [STK_W-1:0]             r_cur;
    logic [DEPTH_W-1:0]           r_idx;
    logic [DEPTH_W-1:0]           r_depth;
    logic [DEPTH_W-1:0]           r_fill [NUM_STACKS];
    logic                         r_out_valid;
    logic [pms_pkg::STATUS_W-1:0] r_out_status;
    logic                         r_out_id;
    logic [pms_pkg::VALUE_W-1:0]  r_out_value;
    logic                         r_out_last;

    logic [DEPTH_W-1:0]           w_fill_cur;
    logic [DEPTH_W-1:0]           w_rd_off;
    logic [DEPTH_W-1:0]           w_cfg_depth;
    logic [ADDR_W-1:0]            w_base;
    logic [ADDR_W-1:0]            w_waddr;
    logic [ADDR_W-1:0]            w_raddr;
    logic [pms_pkg::VALUE_W-1:0]  w_rdata;
    logic                         w_out_free;
    logic                         n_out_valid;

    // Depth write clamped into 1..MAX_DEPTH
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg_depth = DEPTH_W'(1);
        end else if (i_cfg_wdata > pms_pkg::CFG_W'(MAX_DEPTH)) begin
            w_cfg_depth = DEPTH_W'(MAX_DEPTH);
        end else begin
            w_cfg_depth = DEPTH_W'(i_cfg_wdata);
        end
    end

    // Partition base and memory addresses
    assign w_fill_cur = r_fill[r_cur];
    assign w_base     = ADDR_W'(r_cur) * ADDR_W'(r_depth);
    assign w_rd_off   = i_cmd.list_rd ? r_idx : DEPTH_W'(w_fill_cur - DEPTH_W'(1));
    assign w_waddr    = w_base + ADDR_W'(w_fill_cur);
    assign w_raddr    = w_base + ADDR_W'(w_rd_off);

    pms_ram #(
        .WIDTH (pms_pkg::VALUE_W),
        .DEPTH (MEM_D)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_wr),
        .i_waddr (w_waddr),
        .i_wdata (r_value),
        .i_re    (i_cmd.pop_rd | i_cmd.list_rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Item capture and listing cursor; stack_sel is zero-extended into the stack
    // number as it stands and does not wrap onto the stack count
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_cur   <= STK_W'(i_sel);
        end else if (i_cmd.list_init) begin
            if (r_op == pms_pkg::OP_LIST_ALL) begin
                r_cur <= '0;
            end
        end else if (i_cmd.next_stack) begin
            r_cur <= STK_W'(r_cur + STK_W'(1));
        end
        if (i_cmd.list_init || i_cmd.next_stack) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= DEPTH_W'(r_idx + DEPTH_W'(1));
        end
    end

    // Depth register and fill counts; a depth write empties every stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_W'(RST_D);
            for (int s = 0; s < NUM_STACKS; s++) begin
                r_fill[s] <= '0;
            end
        end else if (i_cfg_we) begin
            r_depth <= w_cfg_depth;
            for (int s = 0; s < NUM_STACKS; s++) begin
                r_fill[s] <= '0;
            end
        end else if (i_cmd.push_wr) begin
            r_fill[r_cur] <= DEPTH_W'(w_fill_cur + DEPTH_W'(1));
        end else if (i_cmd.pop_rd) begin
            r_fill[r_cur] <= DEPTH_W'(w_fill_cur - DEPTH_W'(1));
        end
    end

    // Output register
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign n_out_valid = i_cmd.emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_id     <= i_cmd.emit_zero_id ? 1'b0 : r_cur[0];
            r_out_value  <= i_cmd.emit_rdata ? w_rdata : '0;
            r_out_last   <= i_cmd.emit_last;
        end
    end

    // Status toward the controller
    always_comb begin
        o_sts.op        = r_op;
        o_sts.full      = (w_fill_cur >= r_depth);
        o_sts.empty     = (w_fill_cur == '0);
        o_sts.list_more = (r_idx < w_fill_cur);
        o_sts.has_next  = (r_cur != STK_W'(NUM_STACKS - 1));
        o_sts.out_free  = w_out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_id     = r_out_id;
    assign o_out_value  = r_out_value;
    assign o_out_last   = r_out_last;

endmodule

// ===== design/pms_ctrl.sv =====
// Controller: sequences push, pop and listing walks over the datapath.
module pms_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pms_pkg::t_sts i_sts,
    output pms_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_EXEC      = 5'b00010,
        S_POP_WAIT  = 5'b00100,
        S_LIST      = 5'b01000,
        S_LIST_WAIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.op)
                    pms_pkg::OP_PUSH: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_last = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.emit_status = pms_pkg::ST_OVERFLOW;
                            end else begin
                                o_cmd.push_wr     = 1'b1;
                                o_cmd.emit_status = pms_pkg::ST_PUSHED;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    pms_pkg::OP_POP: begin
                        if (!i_sts.empty) begin
                            o_cmd.pop_rd = 1'b1;
                            n_state      = S_POP_WAIT;
                        end else if (i_sts.out_free) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = pms_pkg::ST_UNDERFLOW;
                            n_state           = S_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.list_init = 1'b1;
                        n_state         = S_LIST;
                    end
                endcase
            end
            S_POP_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_rdata  = 1'b1;
                    o_cmd.emit_status = pms_pkg::ST_POPPED;
                    n_state           = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_sts.list_more) begin
                    o_cmd.list_rd = 1'b1;
                    n_state       = S_LIST_WAIT;
                end else if (i_sts.op == pms_pkg::OP_LIST_ALL && i_sts.has_next) begin
                    o_cmd.next_stack = 1'b1;
                end else if (i_sts.out_free) begin
                    // end marker; list-all reports stack zero
                    o_cmd.emit         = 1'b1;
                    o_cmd.emit_last    = 1'b1;
                    o_cmd.emit_status  = pms_pkg::ST_END;
                    o_cmd.emit_zero_id = (i_sts.op == pms_pkg::OP_LIST_ALL);
                    n_state            = S_IDLE;
                end
            end
            S_LIST_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_rdata  = 1'b1;
                    o_cmd.emit_status = pms_pkg::ST_LISTED;
                    o_cmd.idx_inc     = 1'b1;
                    n_state           = S_LIST;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/partitioned_multi_stack_unit.sv =====
// Top level of the partitioned multi-stack unit.
//
// Several stacks share one element memory, each in a fixed partition of
// stack_depth entries. Input items arrive on s_axis: tuser carries op and
// stack_sel, tdata the value to push. Results leave on m_axis: tuser carries
// status and stack id, tdata the popped or listed value, tlast marks the
// final result of an item. The user writes stack_depth through i_cfg_we only
// while the unit is idle; the block does not enforce it. A write empties all stacks.
// After an item is accepted, push, overflow and underflow results are loaded
// into the output register from the execute state, pop results from the
// pop-wait state after the memory read; the unit then returns to idle, and only
// there is the next item taken. A listing starts its walk, then for each live
// entry reads memory and loads the output register, switches stacks as needed
// and ends with the end marker; the input is held off for the whole walk.
// The rate is set by the registered memory read and the one-entry output register.
// Reset clears all fill counts, sets stack_depth to its default and drops
// the output register; memory contents are left as they are. When the
// receiver stalls, the result stays in the output register and the walk
// or the next item waits for it.
module partitioned_multi_stack_unit #(
    parameter int NUM_STACKS = pms_pkg::NUM_STACKS_DEF,
    parameter int MAX_DEPTH  = pms_pkg::MAX_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [pms_pkg::CFG_W-1:0]   i_cfg_wdata,     // stack_depth
    // input items
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [pms_pkg::VALUE_W-1:0] s_axis_tdata,    // [31:0] value
    input  logic [2:0]                  s_axis_tuser,    // [1:0] op, [2] stack_sel
    // result items
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [pms_pkg::VALUE_W-1:0] m_axis_tdata,    // [31:0] element_value
    output logic [3:0]                  m_axis_tuser,    // [2:0] status, [3] stack_id
    output logic                        m_axis_tlast
);

    pms_pkg::t_cmd                w_cmd;
    pms_pkg::t_sts                w_sts;
    logic [pms_pkg::STATUS_W-1:0] w_out_status;
    logic                         w_out_id;

    pms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pms_dpath #(
        .NUM_STACKS (NUM_STACKS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_op         (pms_pkg::t_op'(s_axis_tuser[1:0])),
        .i_sel        (s_axis_tuser[2]),
        .i_value      (s_axis_tdata),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (w_out_status),
        .o_out_id     (w_out_id),
        .o_out_value  (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = {w_out_id, w_out_status};

endmodule

// ===== design/pms_checker.sv =====
// Port-level assertions for the partitioned multi-stack unit, bound to the top level.
module pms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result item holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result item changed while stalled");

    // One item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // Only listed elements come without tlast
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tuser[2:0] == 3'(pms_pkg::ST_LISTED)) == !m_axis_tlast))
        else $error("tlast does not match result status");

    // Input stays closed while a listing is still running
    a_list_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input open during a listing");

    // Results without a value carry zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] == 3'(pms_pkg::ST_PUSHED)
            || m_axis_tuser[2:0] == 3'(pms_pkg::ST_OVERFLOW)
            || m_axis_tuser[2:0] == 3'(pms_pkg::ST_UNDERFLOW)
            || m_axis_tuser[2:0] == 3'(pms_pkg::ST_END)) |->
            m_axis_tdata == '0)
        else $error("nonzero data on a result without value");

endmodule

bind partitioned_multi_stack_unit pms_checker u_pms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for the partitioned multi-stack unit.
`timescale 1ns / 100ps

module testbench;

    localparam int STACKS       = pms_pkg::NUM_STACKS_DEF;
    localparam int DEPTH_MAX    = pms_pkg::MAX_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_PCT     = 31;

    // One expected result item
    typedef struct {
        pms_pkg::t_status status;
        logic             sid;
        logic [31:0]      value;
        logic             last;
    } t_stack_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [31:0] value
    logic [2:0]  s_axis_tuser = '0;    // [1:0] op, [2] stack_sel
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] element_value
    logic [3:0]  m_axis_tuser;         // [2:0] status, [3] stack_id
    logic        m_axis_tlast;

    // Predictor state
    logic [31:0] mdl_store [STACKS*DEPTH_MAX];
    int          mdl_fill  [STACKS];
    int          mdl_depth;
    t_stack_result pending_results [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  steady = 1'b0;      // no idling on either side
    int  hold_req = 0;       // receiver hold-off request, in cycles
    int  hold_left = 0;

    partitioned_multi_stack_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** partitioned_multi_stack_unit: FAILED **");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_stack_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d id %0d value %h last %0d",
                             m_axis_tuser[2:0], m_axis_tuser[3], m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser[2:0] !== want.status || m_axis_tuser[3] !== want.sid ||
                    m_axis_tdata !== want.value || m_axis_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: exp status %0d id %0d value %h last %0d,",
                                  " got %0d %0d %h %0d"},
                                 want.status, want.sid, want.value, want.last,
                                 m_axis_tuser[2:0], m_axis_tuser[3],
                                 m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    function automatic void add_result(pms_pkg::t_status st, logic sid, logic [31:0] v,
                                       logic last);
        t_stack_result r;
        r.status = st;
        r.sid    = sid;
        r.value  = v;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    function automatic void list_one_stack(int s);
        for (int i = 0; i < mdl_fill[s]; i++)
            add_result(pms_pkg::ST_LISTED, s[0], mdl_store[s * mdl_depth + i], 1'b0);
    endfunction

    // Expected results of one accepted item
    function automatic void predict_stack_op(pms_pkg::t_op op, logic sel, logic [31:0] val);
        int s;
        s = int'(sel);
        case (op)
            pms_pkg::OP_PUSH: begin
                if (mdl_fill[s] >= mdl_depth) begin
                    add_result(pms_pkg::ST_OVERFLOW, sel, '0, 1'b1);
                end else begin
                    mdl_store[s * mdl_depth + mdl_fill[s]] = val;
                    mdl_fill[s]++;
                    add_result(pms_pkg::ST_PUSHED, sel, '0, 1'b1);
                end
            end
            pms_pkg::OP_POP: begin
                if (mdl_fill[s] == 0) begin
                    add_result(pms_pkg::ST_UNDERFLOW, sel, '0, 1'b1);
                end else begin
                    mdl_fill[s]--;
                    add_result(pms_pkg::ST_POPPED, sel,
                               mdl_store[s * mdl_depth + mdl_fill[s]], 1'b1);
                end
            end
            pms_pkg::OP_LIST: begin
                list_one_stack(s);
                add_result(pms_pkg::ST_END, sel, '0, 1'b1);
            end
            default: begin
                for (int t = 0; t < STACKS; t++)
                    list_one_stack(t);
                add_result(pms_pkg::ST_END, 1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    // Offer one item, with a random gap before it unless steady, and wait for acceptance.
    // tvalid stays high afterwards; stop_sending lowers it.
    task automatic issue_item(pms_pkg::t_op op, logic sel, logic [31:0] val);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= {sel, op};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_stack_op(op, sel, val);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Depth write while idle; empties every stack
    task automatic set_depth(logic [4:0] d);
        stop_sending();
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_depth = (d == 0) ? 1 : (int'(d) > DEPTH_MAX) ? DEPTH_MAX : int'(d);
        for (int s = 0; s < STACKS; s++) mdl_fill[s] = 0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return 32'h0;
            1: begin
                case ($urandom_range(2))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // One random item: push_pct pushes, a few listings, pops for the rest
    task automatic issue_random(int push_pct);
        int r;
        pms_pkg::t_op op;
        r = $urandom_range(99);
        if (r < push_pct)
            op = pms_pkg::OP_PUSH;
        else if (r < push_pct + 8)
            op = pms_pkg::OP_LIST;
        else if (r < push_pct + 15)
            op = pms_pkg::OP_LIST_ALL;
        else
            op = pms_pkg::OP_POP;
        issue_item(op, 1'($urandom_range(1)), pick_value());
    endtask

    // Empty stacks, extreme values, every operation at the reset depth
    task automatic test_directed_basics();
        issue_item(pms_pkg::OP_POP, 1'b0, $urandom());
        issue_item(pms_pkg::OP_POP, 1'b1, $urandom());
        issue_item(pms_pkg::OP_LIST, 1'b0, $urandom());
        issue_item(pms_pkg::OP_LIST_ALL, 1'b1, $urandom());
        issue_item(pms_pkg::OP_PUSH, 1'b0, 32'h0000_0000);
        issue_item(pms_pkg::OP_PUSH, 1'b0, 32'h8000_0000);
        issue_item(pms_pkg::OP_PUSH, 1'b0, 32'h7fff_ffff);
        issue_item(pms_pkg::OP_PUSH, 1'b1, 32'hffff_ffff);
        issue_item(pms_pkg::OP_PUSH, 1'b1, 32'h0000_0001);
        issue_item(pms_pkg::OP_LIST, 1'b0, $urandom());
        issue_item(pms_pkg::OP_LIST, 1'b1, $urandom());
        issue_item(pms_pkg::OP_LIST_ALL, 1'b0, $urandom());
        issue_item(pms_pkg::OP_POP, 1'b1, $urandom());
        issue_item(pms_pkg::OP_POP, 1'b0, $urandom());
    endtask

    // Depth write of zero acts as one: overflow right after the first push
    task automatic test_depth_one();
        set_depth(5'd0);
        issue_item(pms_pkg::OP_PUSH, 1'b0, 32'h0000_0005);
        issue_item(pms_pkg::OP_PUSH, 1'b0, 32'h1234_5678);
        issue_item(pms_pkg::OP_PUSH, 1'b1, 32'ha5a5_a5a5);
        issue_item(pms_pkg::OP_PUSH, 1'b1, 32'h5a5a_5a5a);
        issue_item(pms_pkg::OP_LIST_ALL, 1'b1, $urandom());
        issue_item(pms_pkg::OP_POP, 1'b0, $urandom());
        issue_item(pms_pkg::OP_POP, 1'b0, $urandom());
    endtask

    task automatic test_random_mix(int n, int push_pct);
        for (int i = 0; i < n; i++)
            issue_random(push_pct);
    endtask

    // Long receiver hold-off while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        set_depth(5'd16);
        hold_req = 300;
        test_random_mix(40, 70);
    endtask

    // Sender pauses until every result is back, then resumes
    task automatic test_drain_pause();
        test_random_mix(10, 60);
        stop_sending();
        wait_drained();
        test_random_mix(10, 40);
    endtask

    initial begin
        mdl_depth = pms_pkg::DEPTH_RESET;
        for (int s = 0; s < STACKS; s++) mdl_fill[s] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_depth_one();

        set_depth(5'd31);
        test_random_mix(80, 80);
        set_depth(5'd1);
        test_random_mix(50, 50);

        // stretch without idling on either side
        set_depth(5'd5);
        steady = 1'b1;
        test_random_mix(60, 55);
        stop_sending();
        steady = 1'b0;

        test_output_backpressure();
        set_depth(5'd17);
        test_random_mix(60, 60);
        set_depth(5'($urandom_range(15, 2)));
        test_random_mix(60, 55);
        set_depth(5'd0);
        test_random_mix(40, 50);
        test_drain_pause();

        stop_sending();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("** partitioned_multi_stack_unit: PASSED **");
        end else begin
            $display("** partitioned_multi_stack_unit: FAILED **");
        end
        $finish;
    end

endmodule
